@@ rtl/rde_pkg.sv @@
package rde_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// divisor width: covers 2*10^15 for fraction scaling and 2^31 for operands
	localparam int DEN_W      = 51;
	localparam int FRAC_LIMIT = 15;

	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	// 2 * 10^k, the rounding divisor of the k-th fraction digit
	localparam logic [DEN_W-1:0] TWO_POW_TEN [16] = '{
		51'd2, 51'd20, 51'd200, 51'd2000, 51'd20000, 51'd200000,
		51'd2000000, 51'd20000000, 51'd200000000, 51'd2000000000,
		51'd20000000000, 51'd200000000000, 51'd2000000000000,
		51'd20000000000000, 51'd200000000000000, 51'd2000000000000000
	};

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_START, CMD_INT_DIGIT, CMD_FRAC_GO, CMD_FRAC_ADD, CMD_PUSH,
		CMD_UNDER, CMD_READ, CMD_LOAD, CMD_ADDSUB, CMD_MUL_GO, CMD_MUL_FIN,
		CMD_DIVZ, CMD_DIV_GO, CMD_DIV_FIN, CMD_EMIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		op_t        op;
		logic       neg;
		logic [3:0] digit;
	} cmd_t;

	typedef struct packed {
		logic count_lt2;
		logic top_zero;
		logic fd_lt15;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/rpn_decimal_evaluator.sv @@
// A character is accepted only from the idle state, so one character is in flight at a time.
// The first digit of a number adds an accumulation step; + - * / run the operator sequence
// (read, load, execute), and / and fraction digits wait on the shared restoring divider, one
// divider step per cycle. A minus resolved as subtraction runs the operator steps, and the last
// character adds a finish step that pushes any number in progress and emits the result beat.
// Reset (arst_n low, asynchronous): empty stack, status ok.
module rpn_decimal_evaluator import rde_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tlast,  // is_last: final character of the expression
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] value (Q format), [34:32] status, rest zero
);

	cmd_t        cmd;
	dp_stat_t    stat;
	logic [31:0] value;
	logic [2:0]  status;

	// Controller walks each character through a short command sequence:
	// sign resolution, digit accumulation, number push, operator, and the
	// final emit. It accepts a new beat only when back in its idle state.
	rde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: operand stack (top cached in a register, the rest in RAM),
	// number accumulator, multiplier, divider and the output register, which
	// holds a result beat while the next expression is already being read.
	rde_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.out_value  (value),
		.out_status (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {5'd0, status, value};

endmodule

@@ rtl/rde_ram.sv @@
module rde_ram import rde_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/rde_div.sv @@
module rde_div import rde_pkg::*; #(
	parameter int NUM_W   = 51,
	parameter int SHORT_N = FRAC_BITS_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             short_mode,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] work_q;
	logic [DEN_W:0]   rem_t;
	logic             ge;
	logic [DEN_W:0]   rem_n;

	// one restoring step per cycle
	always_comb begin
		rem_t = {rem_q, work_q[NUM_W-1]};
		ge    = rem_t >= {1'b0, den_q};
		rem_n = ge ? (rem_t - {1'b0, den_q}) : rem_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= short_mode ? CNT_W'(SHORT_N) : CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (short_mode) begin
				// quotient known to fit SHORT_N bits: skip the leading steps
				rem_q  <= DEN_W'(num >> SHORT_N);
				work_q <= num << (NUM_W - SHORT_N);
			end else begin
				rem_q  <= '0;
				work_q <= num;
			end
		end else if (busy_q) begin
			rem_q  <= rem_n[DEN_W-1:0];
			work_q <= {work_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = work_q;

endmodule

@@ rtl/rde_dp.sv @@
module rde_dp import rde_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output dp_stat_t    stat,
	output logic [31:0] out_value,
	output logic [2:0]  out_status,
	output logic        out_valid,
	input  logic        out_ready
);

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CW    = $clog2(STACK_DEPTH + 1);
	localparam int NUM_W = (32 + FRAC_BITS > DEN_W) ? 32 + FRAC_BITS : DEN_W;
	localparam int QF    = FRAC_BITS + 1;

	logic [CW-1:0]      count_q;
	logic [31:0]        top_q;
	logic [31:0]        accum_q;
	logic [3:0]         fd_q;
	logic               neg_q;
	logic [2:0]         sticky_q;
	logic [31:0]        a_q;
	logic [31:0]        b_q;
	logic [31:0]        ma_q;
	logic [31:0]        mb_q;
	logic               sgn_q;
	logic [63:0]        prod_s1;
	logic               out_valid_q;
	logic [31:0]        out_value_q;
	logic [2:0]         out_status_q;

	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      cnt_m2;
	logic               full;
	logic               ram_we;
	logic [31:0]        ram_rdata;
	logic [31:0]        push_val;
	logic [35:0]        cap;
	logic [35:0]        int_sum;
	logic [35:0]        frac_sum;
	logic [35:0]        acc_in;
	logic               acc_over;
	logic [32:0]        sum33;
	logic [63:0]        mul_m;
	logic [32:0]        res;
	logic               flag_en;
	logic [2:0]         flag_code;
	logic               div_start;
	logic               div_short;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic [DEN_W-1:0]   pow2;
	logic               out_free;

	// {overflow, value} from sign and magnitude
	function automatic logic [32:0] from_mag(logic neg, logic [63:0] mag);
		logic [32:0] r;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[31:0]};
		end else begin
			if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'd0 - mag[31:0]};
		end
		return r;
	endfunction

	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign full     = count_q >= CW'(STACK_DEPTH);
	assign ram_we   = (cmd.kind == CMD_PUSH) && !full && (count_q != '0);
	assign push_val = neg_q ? (32'd0 - accum_q) : accum_q;
	assign out_free = !out_valid_q || out_ready;
	assign pow2     = TWO_POW_TEN[fd_q + 4'd1];

	rde_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_m1[AW-1:0]),
		.wdata (top_q),
		.re    (cmd.kind == CMD_READ),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign div_start = (cmd.kind == CMD_FRAC_GO) || (cmd.kind == CMD_DIV_GO);
	assign div_short = cmd.kind == CMD_FRAC_GO;
	always_comb begin
		if (div_short) begin
			div_num = (NUM_W'(cmd.digit) << (FRAC_BITS + 1)) + NUM_W'(pow2 >> 1);
			div_den = pow2;
		end else begin
			div_num = (NUM_W'(ma_q) << FRAC_BITS) + NUM_W'(mb_q >> 1);
			div_den = DEN_W'(mb_q);
		end
	end

	rde_div #(.NUM_W(NUM_W), .SHORT_N(QF)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.short_mode (div_short),
		.num        (div_num),
		.den        (div_den),
		.done       (div_done),
		.quo        (div_quo)
	);

	// number accumulation with magnitude cap
	always_comb begin
		cap      = neg_q ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
		int_sum  = (36'(accum_q) << 3) + (36'(accum_q) << 1) + (36'(cmd.digit) << FRAC_BITS);
		frac_sum = 36'(accum_q) + 36'(div_quo[QF-1:0]);
		acc_in   = (cmd.kind == CMD_FRAC_ADD) ? frac_sum : int_sum;
		acc_over = acc_in > cap;
	end

	// arithmetic result
	always_comb begin
		if (cmd.op == OP_SUB) sum33 = {a_q[31], a_q} - {b_q[31], b_q};
		else sum33 = {a_q[31], a_q} + {b_q[31], b_q};
		mul_m = (prod_s1 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		case (cmd.kind)
			CMD_ADDSUB: begin
				if (sum33[32] != sum33[31])
					res = {1'b1, sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
				else
					res = {1'b0, sum33[31:0]};
			end
			CMD_MUL_FIN: res = from_mag(sgn_q, mul_m);
			CMD_DIV_FIN: res = from_mag(sgn_q, 64'(div_quo));
			CMD_DIVZ: begin
				if (a_q == 32'd0) res = {1'b0, 32'd0};
				else if (a_q[31]) res = {1'b0, 32'h8000_0000};
				else res = {1'b0, 32'h7FFF_FFFF};
			end
			default: res = '0;
		endcase
	end

	always_comb begin
		flag_en   = 1'b0;
		flag_code = ST_OK;
		case (cmd.kind)
			CMD_PUSH: begin
				flag_en   = full;
				flag_code = ST_OVER;
			end
			CMD_INT_DIGIT, CMD_FRAC_ADD: begin
				flag_en   = acc_over;
				flag_code = ST_OVER;
			end
			CMD_UNDER: begin
				flag_en   = 1'b1;
				flag_code = ST_UNDER;
			end
			CMD_ADDSUB, CMD_MUL_FIN, CMD_DIV_FIN: begin
				flag_en   = res[32];
				flag_code = ST_OVER;
			end
			CMD_DIVZ: begin
				flag_en   = 1'b1;
				flag_code = ST_DIVZ;
			end
			default: begin
				flag_en   = 1'b0;
				flag_code = ST_OK;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			accum_q     <= '0;
			fd_q        <= '0;
			neg_q       <= 1'b0;
			sticky_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result beat, or drop the one taken downstream
			if (cmd.kind == CMD_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (flag_en && sticky_q == ST_OK) sticky_q <= flag_code;
			case (cmd.kind)
				CMD_START: begin
					accum_q <= '0;
					fd_q    <= '0;
					neg_q   <= cmd.neg;
				end
				CMD_INT_DIGIT: accum_q <= acc_over ? cap[31:0] : acc_in[31:0];
				CMD_FRAC_ADD: begin
					accum_q <= acc_over ? cap[31:0] : acc_in[31:0];
					fd_q    <= fd_q + 4'd1;
				end
				CMD_PUSH: begin
					if (!full) count_q <= count_q + CW'(1);
					accum_q <= '0;
					fd_q    <= '0;
					neg_q   <= 1'b0;
				end
				CMD_ADDSUB, CMD_MUL_FIN, CMD_DIV_FIN, CMD_DIVZ: count_q <= cnt_m1;
				CMD_EMIT: begin
					count_q     <= '0;
					accum_q     <= '0;
					fd_q        <= '0;
					neg_q       <= 1'b0;
					sticky_q    <= ST_OK;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_PUSH: if (!full) top_q <= push_val;
			CMD_LOAD: begin
				a_q   <= ram_rdata;
				b_q   <= top_q;
				ma_q  <= ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;
				mb_q  <= top_q[31] ? (32'd0 - top_q) : top_q;
				sgn_q <= ram_rdata[31] ^ top_q[31];
			end
			CMD_MUL_GO: prod_s1 <= 64'(ma_q) * 64'(mb_q);
			CMD_ADDSUB, CMD_MUL_FIN, CMD_DIV_FIN, CMD_DIVZ: top_q <= res[31:0];
			CMD_EMIT: begin
				out_value_q <= (count_q != '0) ? top_q : 32'd0;
				if (sticky_q != ST_OK) out_status_q <= sticky_q;
				else if (count_q == '0) out_status_q <= ST_EMPTY;
				else out_status_q <= ST_OK;
			end
			default: ;
		endcase
	end

	assign stat.count_lt2 = count_q < CW'(2);
	assign stat.top_zero  = top_q == 32'd0;
	assign stat.fd_lt15   = fd_q < 4'(FRAC_LIMIT);
	assign stat.div_done  = div_done;
	assign stat.out_free  = out_free;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_accum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accum_q <= 32'h8000_0000)
		else $error("number magnitude beyond cap");

	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ST_OK && cmd.kind != CMD_EMIT) |=> $stable(sticky_q))
		else $error("first error overwritten");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.kind == CMD_EMIT) |=> (count_q == '0 && sticky_q == ST_OK && out_valid_q))
		else $error("emit did not clear the evaluator");

endmodule

@@ rtl/rde_ctrl.sv @@
module rde_ctrl import rde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	input  dp_stat_t   stat,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_NORMAL, S_DIGIT, S_FRAC_WAIT, S_OP_READ, S_OP_LOAD,
		S_OP_RUN, S_MUL_FIN, S_DIV_WAIT, S_FINISH, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_IDLE, PH_INT, PH_FRAC, PH_MINUS} phase_t;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	op_t        op_q, op_d;
	logic       ret_normal_q, ret_normal_d;
	logic [7:0] char_q;
	logic       last_q;
	logic       is_digit;
	logic       in_number;
	op_t        char_op;
	state_t     ret_state;

	assign is_digit  = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign in_number = (phase_q == PH_INT) || (phase_q == PH_FRAC);
	assign ret_state = ret_normal_q ? S_NORMAL : S_FINISH;
	assign in_ready  = state_q == S_IDLE;

	always_comb begin
		case (char_q)
			CH_PLUS:  char_op = OP_ADD;
			CH_STAR:  char_op = OP_MUL;
			CH_SLASH: char_op = OP_DIV;
			default:  char_op = OP_SUB;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		op_d         = op_q;
		ret_normal_d = ret_normal_q;
		cmd.kind     = CMD_NONE;
		cmd.op       = op_q;
		cmd.neg      = 1'b0;
		cmd.digit    = char_q[3:0];
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH, S_NORMAL: begin
				if (state_q == S_DISPATCH && phase_q == PH_MINUS) begin
					// resolve a pending minus: sign or subtraction
					if (is_digit) begin
						cmd.kind = CMD_START;
						cmd.neg  = 1'b1;
						phase_d  = PH_INT;
						state_d  = S_DIGIT;
					end else if (char_q == CH_DOT) begin
						cmd.kind = CMD_START;
						cmd.neg  = 1'b1;
						phase_d  = PH_FRAC;
						state_d  = S_FINISH;
					end else begin
						phase_d      = PH_IDLE;
						op_d         = OP_SUB;
						ret_normal_d = 1'b1;
						state_d      = S_OP_READ;
					end
				end else if (is_digit) begin
					if (phase_q == PH_INT) begin
						cmd.kind = CMD_INT_DIGIT;
						state_d  = S_FINISH;
					end else if (phase_q == PH_FRAC) begin
						if (stat.fd_lt15) begin
							cmd.kind = CMD_FRAC_GO;
							state_d  = S_FRAC_WAIT;
						end else begin
							state_d = S_FINISH;
						end
					end else begin
						cmd.kind = CMD_START;
						phase_d  = PH_INT;
						state_d  = S_DIGIT;
					end
				end else if (char_q == CH_DOT) begin
					if (phase_q == PH_IDLE) cmd.kind = CMD_START;
					phase_d = PH_FRAC;
					state_d = S_FINISH;
				end else begin
					// every other character ends a number in progress
					if (in_number) begin
						cmd.kind = CMD_PUSH;
						phase_d  = PH_IDLE;
					end
					ret_normal_d = 1'b0;
					op_d         = char_op;
					if (char_q == CH_PLUS || char_q == CH_STAR || char_q == CH_SLASH) begin
						state_d = S_OP_READ;
					end else if (char_q == CH_MINUS) begin
						if (last_q) begin
							state_d = S_OP_READ;
						end else begin
							phase_d = PH_MINUS;
							state_d = S_FINISH;
						end
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_DIGIT: begin
				cmd.kind = CMD_INT_DIGIT;
				state_d  = S_FINISH;
			end
			S_FRAC_WAIT: begin
				if (stat.div_done) begin
					cmd.kind = CMD_FRAC_ADD;
					state_d  = S_FINISH;
				end
			end
			S_OP_READ: begin
				if (stat.count_lt2) begin
					cmd.kind = CMD_UNDER;
					state_d  = ret_state;
				end else begin
					cmd.kind = CMD_READ;
					state_d  = S_OP_LOAD;
				end
			end
			S_OP_LOAD: begin
				cmd.kind = CMD_LOAD;
				state_d  = S_OP_RUN;
			end
			S_OP_RUN: begin
				case (op_q)
					OP_ADD, OP_SUB: begin
						cmd.kind = CMD_ADDSUB;
						state_d  = ret_state;
					end
					OP_MUL: begin
						cmd.kind = CMD_MUL_GO;
						state_d  = S_MUL_FIN;
					end
					default: begin
						if (stat.top_zero) begin
							cmd.kind = CMD_DIVZ;
							state_d  = ret_state;
						end else begin
							cmd.kind = CMD_DIV_GO;
							state_d  = S_DIV_WAIT;
						end
					end
				endcase
			end
			S_MUL_FIN: begin
				cmd.kind = CMD_MUL_FIN;
				state_d  = ret_state;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.kind = CMD_DIV_FIN;
					state_d  = ret_state;
				end
			end
			S_FINISH: begin
				if (last_q) begin
					if (in_number) begin
						cmd.kind = CMD_PUSH;
						phase_d  = PH_IDLE;
					end
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.kind = CMD_EMIT;
					phase_d  = PH_IDLE;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_IDLE;
			op_q         <= OP_ADD;
			ret_normal_q <= 1'b0;
			char_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			op_q         <= op_d;
			ret_normal_q <= ret_normal_d;
			if (in_valid && in_ready) begin
				char_q <= in_char;
				last_q <= in_last;
			end
		end
	end

endmodule
